>>> design/dfhe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfhe_pkg: shared types and constants of the fixed Huffman deflate encoder
// Transaction payloads, the symbol record passed from front to back, and the
// zlib/block header constants.
// ----------------------------------------------------------------------------
package dfhe_pkg;

  typedef enum logic [1:0] {
    MODE_LITERAL  = 2'd0,
    MODE_LENGTH   = 2'd1,
    MODE_DISTANCE = 2'd2,
    MODE_FINISH   = 2'd3
  } mode_e;

  typedef struct packed {
    mode_e       mode;
    logic [15:0] value;
    logic [31:0] checksum;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_item;
    logic       end_of_stream;
  } out_item_t;

  // Bits of one item in stream order (bit 0 goes out first).
  localparam int unsigned SymBitsW  = 21;
  localparam int unsigned SymCountW = 5;

  typedef struct packed {
    logic                  zlib_hdr;  // emit the two zlib header bytes first
    logic                  finish;    // flush and append checksum
    logic [SymBitsW-1:0]   bits;
    logic [SymCountW-1:0]  nbits;
    logic [31:0]           checksum;
  } sym_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  localparam logic [7:0] ZlibCmf       = 8'h78;
  localparam logic [7:0] ZlibFlg       = 8'h5E;
  // BFINAL=1, BTYPE=fixed, already in transmit order.
  localparam logic [2:0] BlockHdrBits  = 3'b011;
  localparam logic [2:0] BlockHdrCount = 3'd3;

  localparam int unsigned QueueDepthDef = 2;

endpackage

>>> design/dfhe_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfhe_front: symbol classifier
// Accepts input transactions, clamps values, maps them to fixed Huffman codes
// plus extra bits in stream order and pushes one record into the queue.
// ----------------------------------------------------------------------------
module dfhe_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  dfhe_pkg::in_item_t      in_item_i,
  input  dfhe_pkg::fifo_status_t  q_status_i,
  output logic                    q_push_o,
  output dfhe_pkg::sym_t          q_data_o
);

  logic        header_sent_q, header_sent_d;
  logic [8:0]  code;
  logic [3:0]  hn;
  logic [3:0]  xb;
  logic [14:0] ext;
  logic [7:0]  lit;
  logic [7:0]  ls;
  logic [14:0] ds;
  logic [4:0]  loff;
  logic [8:0]  rev;
  logic [17:0] sym_bits;
  logic [4:0]  nsym;
  logic        hdr;
  logic        fin;

  function automatic logic [3:0] bit_len(logic [14:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 15; i++) begin
      if (v[i]) begin
        n = 4'(i + 1);
      end
    end
    return n;
  endfunction

  // Reverse the low n bits so the code goes out MSB first.
  function automatic logic [8:0] rev_code(logic [8:0] c, logic [3:0] n);
    logic [8:0] r;
    logic [3:0] idx;
    r = '0;
    for (int i = 0; i < 9; i++) begin
      idx = 4'(n - 4'd1 - 4'(i));
      if (4'(i) < n) begin
        r[i] = c[idx];
      end
    end
    return r;
  endfunction

  always_comb begin
    code = '0;
    hn   = '0;
    xb   = '0;
    ext  = '0;
    lit  = (in_item_i.value > 16'd255) ? 8'hFF : in_item_i.value[7:0];
    ls   = '0;
    ds   = '0;
    loff = '0;
    unique case (in_item_i.mode)
      dfhe_pkg::MODE_LITERAL: begin
        if (lit <= 8'd143) begin
          code = 9'(9'd48 + {1'b0, lit});
          hn   = 4'd8;
        end else begin
          code = {1'b1, lit};
          hn   = 4'd9;
        end
      end
      dfhe_pkg::MODE_LENGTH: begin
        if (in_item_i.value < 16'd3) begin
          ls = 8'd0;
        end else begin
          ls = 8'(in_item_i.value - 16'd3);
        end
        if (in_item_i.value >= 16'd258) begin
          code = 9'd197;
          hn   = 4'd8;
        end else if (ls < 8'd8) begin
          code = 9'(ls + 8'd1);
          hn   = 4'd7;
        end else begin
          xb   = 4'(bit_len({7'd0, ls}) - 4'd3);
          loff = 5'({xb, 2'b00} + 6'd4 + {4'd0, 2'(ls >> xb)});
          ext  = {7'd0, ls} & 15'((16'd1 << xb) - 16'd1);
          if (loff <= 5'd22) begin
            code = 9'(loff + 5'd1);
            hn   = 4'd7;
          end else begin
            code = 9'({4'd0, loff} + 9'd169);
            hn   = 4'd8;
          end
        end
      end
      dfhe_pkg::MODE_DISTANCE: begin
        if (in_item_i.value == 16'd0) begin
          ds = 15'd0;
        end else if (in_item_i.value > 16'd32768) begin
          ds = 15'h7FFF;
        end else begin
          ds = 15'(in_item_i.value - 16'd1);
        end
        hn = 4'd5;
        if (ds < 15'd4) begin
          code = 9'(ds);
        end else begin
          xb   = 4'(bit_len(ds) - 4'd2);
          code = 9'({xb, 1'b0} + 5'd2 + {4'd0, 1'(ds >> xb)});
          ext  = ds & 15'((16'd1 << xb) - 16'd1);
        end
      end
      dfhe_pkg::MODE_FINISH: begin
        code = 9'd0;  // end-of-block: seven zero bits
        hn   = 4'd7;
      end
      default: begin
        code = '0;
      end
    endcase
  end

  assign fin      = (in_item_i.mode == dfhe_pkg::MODE_FINISH);
  assign hdr      = !header_sent_q;
  assign rev      = rev_code(code, hn);
  assign sym_bits = {9'd0, rev} | (18'(ext) << hn);
  assign nsym     = 5'({1'b0, hn} + {1'b0, xb});

  always_comb begin
    q_data_o.zlib_hdr = hdr && !fin;
    q_data_o.finish   = fin;
    q_data_o.checksum = in_item_i.checksum;
    if (hdr) begin
      q_data_o.bits  = {sym_bits, dfhe_pkg::BlockHdrBits};
      q_data_o.nbits = nsym + {2'd0, dfhe_pkg::BlockHdrCount};
    end else begin
      q_data_o.bits  = {3'd0, sym_bits};
      q_data_o.nbits = nsym;
    end
  end

  assign in_stall_o = q_status_i.full;
  assign q_push_o   = in_valid_i && !q_status_i.full;

  // Clear on finish so the next symbol opens a new stream.
  assign header_sent_d = q_push_o ? !fin : header_sent_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_sent_q <= 1'b0;
    end else begin
      header_sent_q <= header_sent_d;
    end
  end

endmodule

>>> design/dfhe_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfhe_fifo: symbol queue
// Small circular buffer of symbol records between the front and the back.
// ----------------------------------------------------------------------------
module dfhe_fifo #(
  parameter int unsigned Depth = dfhe_pkg::QueueDepthDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  dfhe_pkg::sym_t          push_data_i,
  input  logic                    pop_i,
  output dfhe_pkg::sym_t          pop_data_o,
  output dfhe_pkg::fifo_status_t  status_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  dfhe_pkg::sym_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  function automatic logic [PtrW-1:0] ptr_inc(logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : PtrW'(p + 1'b1);
  endfunction

  assign status_o.full  = (count_q == CntW'(Depth));
  assign status_o.empty = (count_q == '0);
  assign pop_data_o     = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= CntW'(count_q + 1'b1);
      end else if (pop_i && !push_i) begin
        count_q <= CntW'(count_q - 1'b1);
      end
    end
  end

endmodule

>>> design/dfhe_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfhe_back: bit packer
// Merges queued symbol bits with the pending bits and sends one byte per
// cycle, unless the output stalls, through a registered output stage.
// ----------------------------------------------------------------------------
module dfhe_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  dfhe_pkg::fifo_status_t  q_status_i,
  input  dfhe_pkg::sym_t          q_data_i,
  output logic                    q_pop_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output dfhe_pkg::out_item_t     out_item_o
);

  typedef enum logic [2:0] {
    PH_ZLIB0,
    PH_ZLIB1,
    PH_DATA,
    PH_SUM0,
    PH_SUM1,
    PH_SUM2,
    PH_SUM3
  } phase_e;

  localparam int unsigned AccW = 28;

  phase_e                        phase_q, phase_d, phase_n;
  logic                          busy_q, busy_d;
  logic                          fin_q, fin_d;
  logic [AccW-1:0]               acc_q, acc_d, acc_n, acc_cur;
  logic [dfhe_pkg::SymCountW-1:0] cnt_q, cnt_d, cnt_n, cnt_cur;
  logic [31:0]                   sum_q, sum_d;
  logic                          out_valid_q, out_valid_d;
  dfhe_pkg::out_item_t           out_q, out_d;

  logic       out_free, emit, last, eos, done_nobyte, adv, retire;
  logic [7:0] byte_val;

  always_comb begin
    emit        = 1'b0;
    last        = 1'b0;
    eos         = 1'b0;
    done_nobyte = 1'b0;
    byte_val    = '0;
    acc_n       = acc_q;
    cnt_n       = cnt_q;
    phase_n     = phase_q;
    if (busy_q) begin
      unique case (phase_q)
        PH_ZLIB0: begin
          emit     = 1'b1;
          byte_val = dfhe_pkg::ZlibCmf;
          phase_n  = PH_ZLIB1;
        end
        PH_ZLIB1: begin
          emit     = 1'b1;
          byte_val = dfhe_pkg::ZlibFlg;
          last     = !fin_q && (cnt_q < 5'd8);
          phase_n  = PH_DATA;
        end
        PH_DATA: begin
          priority if (cnt_q >= 5'd8) begin
            emit     = 1'b1;
            byte_val = acc_q[7:0];
            last     = !fin_q && (cnt_q < 5'd16);
            acc_n    = acc_q >> 8;
            cnt_n    = 5'(cnt_q - 5'd8);
          end else if (fin_q && (cnt_q != '0)) begin
            // pad the partial byte with zeros
            emit     = 1'b1;
            byte_val = acc_q[7:0];
            acc_n    = '0;
            cnt_n    = '0;
            phase_n  = PH_SUM0;
          end else if (fin_q) begin
            emit     = 1'b1;
            byte_val = sum_q[31:24];
            phase_n  = PH_SUM1;
          end else begin
            done_nobyte = 1'b1;
          end
        end
        PH_SUM0: begin
          emit     = 1'b1;
          byte_val = sum_q[31:24];
          phase_n  = PH_SUM1;
        end
        PH_SUM1: begin
          emit     = 1'b1;
          byte_val = sum_q[23:16];
          phase_n  = PH_SUM2;
        end
        PH_SUM2: begin
          emit     = 1'b1;
          byte_val = sum_q[15:8];
          phase_n  = PH_SUM3;
        end
        PH_SUM3: begin
          emit     = 1'b1;
          byte_val = sum_q[7:0];
          last     = 1'b1;
          eos      = 1'b1;
          acc_n    = '0;
          cnt_n    = '0;
        end
        default: begin
          done_nobyte = 1'b1;
        end
      endcase
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign adv      = (emit && out_free) || done_nobyte;
  assign retire   = busy_q && ((emit && last && out_free) || done_nobyte);
  assign q_pop_o  = !q_status_i.empty && (!busy_q || retire);
  assign acc_cur  = adv ? acc_n : acc_q;
  assign cnt_cur  = adv ? cnt_n : cnt_q;

  always_comb begin
    busy_d  = busy_q;
    fin_d   = fin_q;
    sum_d   = sum_q;
    acc_d   = acc_cur;
    cnt_d   = cnt_cur;
    phase_d = adv ? phase_n : phase_q;
    if (q_pop_o) begin
      // pending bits are fewer than eight here
      busy_d  = 1'b1;
      fin_d   = q_data_i.finish;
      sum_d   = q_data_i.checksum;
      acc_d   = acc_cur | (AccW'(q_data_i.bits) << cnt_cur[2:0]);
      cnt_d   = 5'(cnt_cur + q_data_i.nbits);
      phase_d = q_data_i.zlib_hdr ? PH_ZLIB0 : PH_DATA;
    end else if (retire) begin
      busy_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_free) begin
      out_valid_d          = emit;
      out_d.out_byte       = byte_val;
      out_d.last_of_item   = last;
      out_d.end_of_stream  = eos;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_DATA;
      busy_q      <= 1'b0;
      fin_q       <= 1'b0;
      acc_q       <= '0;
      cnt_q       <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      phase_q     <= phase_d;
      busy_q      <= busy_d;
      fin_q       <= fin_d;
      acc_q       <= acc_d;
      cnt_q       <= cnt_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

>>> design/deflate_fixed_huffman_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deflate_fixed_huffman_encoder: zlib stream encoder with fixed Huffman codes
// Turns literal, length, distance and finish transactions into the bytes of
// a single-block fixed-code zlib stream.
// ----------------------------------------------------------------------------
// Each input transaction is a literal, a match length, a match distance or a
// finish request. The first symbol of a stream is preceded by the zlib header
// 0x78 0x5E and the final-block fixed-code header; finish sends end-of-block,
// pads to a byte and appends the Adler-32 checksum most significant byte
// first, then the next symbol starts a fresh stream. Out-of-range values are
// clamped (literal to 255, length to 3..258, distance to 1..32768). The front
// classifies and codes one transaction per cycle into a QueueDepth-entry
// queue while it is not full; the back packs bits and delivers one byte per
// cycle through a registered output unless the output stalls. An item yields
// zero to three bytes for symbols, up to four for the first symbol of a
// stream and up to six for finish. Symbols that complete no byte produce no
// output transaction; their bits stay pending. last_of_item marks the final
// byte of an item and end_of_stream the last checksum byte.
// ----------------------------------------------------------------------------
module deflate_fixed_huffman_encoder #(
  parameter int unsigned QueueDepth = dfhe_pkg::QueueDepthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  dfhe_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output dfhe_pkg::out_item_t  out_item_o
);

  dfhe_pkg::fifo_status_t q_status;
  dfhe_pkg::sym_t         q_push_data;
  dfhe_pkg::sym_t         q_pop_data;
  logic                   q_push;
  logic                   q_pop;

  // Front: clamp, code and queue one transaction per cycle while the queue is not full.
  dfhe_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .q_status_i (q_status),
    .q_push_o   (q_push),
    .q_data_o   (q_push_data)
  );

  // Queue: decouples coding from byte delivery.
  dfhe_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .pop_i       (q_pop),
    .pop_data_o  (q_pop_data),
    .status_o    (q_status)
  );

  // Back: hold pending bits, emit one byte per cycle unless the output stalls.
  dfhe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_status_i  (q_status),
    .q_data_i    (q_pop_data),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // Never write a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_push |-> !q_status.full)
    else $error("symbol queue overflow");

  // Never read an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> !q_status.empty)
    else $error("symbol queue underflow");

  // The closing checksum byte always ends its item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.end_of_stream |-> out_item_o.last_of_item)
    else $error("end of stream without end of item");

endmodule

>>> tb/sv/deflate_fixed_huffman_encoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deflate_fixed_huffman_encoder_tb: self-checking bench for the zlib encoder
// Drives literal, length, distance and finish transactions with random gaps,
// stalls the byte output at random, and checks every byte against typed-in
// bytes or an in-bench bit packer that tracks the pending bits and stream headers.
// ----------------------------------------------------------------------------
module deflate_fixed_huffman_encoder_tb;

  import dfhe_pkg::*;

  localparam int unsigned RandomItems   = 320;
  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned DrainCycles   = 16;
  localparam int unsigned MaxReports    = 40;
  localparam int unsigned NumDirected   = 23;

  // BFINAL=1 then BTYPE=01, written so that MSB-first order sends 1,1,0.
  localparam logic [2:0] FixedBlockHdr = 3'b110;

  // One row of the directed table; n_typed > 0 means the bytes are typed in.
  typedef struct packed {
    in_item_t         item;
    logic [2:0]       n_typed;
    logic [0:5][7:0]  typed;
  } stim_row_t;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  deflate_fixed_huffman_encoder dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Bit packer: mirrors the encoder's stream state.
  // --------------------------------------------------------------------------
  logic [6:0]  carry_bits = '0;   // leftover bits of an unfinished byte
  int unsigned carry_cnt  = 0;
  bit          hdr_done   = 1'b0; // zlib and block headers already out
  logic [7:0]  acc_byte;
  int unsigned acc_cnt;
  logic [7:0]  coded_bytes[$];    // bytes completed by the current transaction

  out_item_t   expected_bytes[$]; // bytes still owed by the encoder

  int unsigned mismatches    = 0;
  int unsigned bytes_checked = 0;
  int unsigned random_items  = 0;
  int unsigned silent_items  = 0;
  int unsigned streams_done  = 0;
  int unsigned mode_count[4] = '{0, 0, 0, 0};

  // Append one completed byte to the current transaction's bytes.
  function automatic void add_coded(input logic [7:0] b);
    coded_bytes = {coded_bytes, b};
  endfunction

  function automatic void pack_bit(input logic b);
    acc_byte[acc_cnt] = b;
    acc_cnt++;
    if (acc_cnt == 8) begin
      add_coded(acc_byte);
      acc_byte = '0;
      acc_cnt  = 0;
    end
  endfunction

  function automatic void emit_msb(input int unsigned code, input int unsigned n);
    for (int i = int'(n) - 1; i >= 0; i--) pack_bit(code[i]);
  endfunction

  function automatic void emit_lsb(input int unsigned bits, input int unsigned n);
    for (int i = 0; i < int'(n); i++) pack_bit(bits[i]);
  endfunction

  // Literal/length alphabet codes 256..287 (lengths and end-of-block).
  function automatic void emit_len_sym(input int unsigned sym);
    if (sym <= 279) begin
      emit_msb(sym - 256, 7);
    end else begin
      emit_msb(192 + (sym - 280), 8);
    end
  endfunction

  function automatic void encode_item(input in_item_t it);
    int unsigned v;
    int unsigned s;
    int unsigned xb;
    int unsigned sym;
    coded_bytes.delete();
    acc_byte = {1'b0, carry_bits};
    acc_cnt  = carry_cnt;
    // Open a stream: a finish with nothing before it skips the zlib bytes.
    if (!hdr_done) begin
      if (it.mode != MODE_FINISH) begin
        add_coded(ZlibCmf);
        add_coded(ZlibFlg);
      end
      emit_msb(32'(FixedBlockHdr), 3);
      hdr_done = 1'b1;
    end
    case (it.mode)
      MODE_LITERAL: begin
        v = (it.value > 255) ? 255 : it.value;
        if (v <= 143) begin
          emit_msb(48 + v, 8);
        end else begin
          emit_msb(400 + (v - 144), 9);
        end
      end
      MODE_LENGTH: begin
        v = (it.value < 3) ? 3 : it.value;
        if (v >= 258) begin
          emit_len_sym(285);
        end else begin
          s = v - 3;
          if (s < 8) begin
            emit_len_sym(257 + s);
          end else begin
            xb  = $clog2(s + 1) - 3;
            sym = 257 + 4 * xb + 4 + ((s >> xb) & 3);
            emit_len_sym(sym);
            emit_lsb(s, xb);
          end
        end
      end
      MODE_DISTANCE: begin
        v = (it.value < 1) ? 1 : ((it.value > 32768) ? 32768 : it.value);
        s = v - 1;
        if (s < 4) begin
          emit_msb(s, 5);
        end else begin
          xb  = $clog2(s + 1) - 2;
          sym = 2 * xb + 2 + ((s >> xb) & 1);
          emit_msb(sym, 5);
          emit_lsb(s, xb);
        end
      end
      default: begin
        // End-of-block, pad to a byte, then the checksum big-endian.
        emit_len_sym(256);
        if (acc_cnt > 0) begin
          add_coded(acc_byte);
          acc_byte = '0;
          acc_cnt  = 0;
        end
        add_coded(it.checksum[31:24]);
        add_coded(it.checksum[23:16]);
        add_coded(it.checksum[15:8]);
        add_coded(it.checksum[7:0]);
      end
    endcase
    if (it.mode == MODE_FINISH) begin
      carry_bits = '0;
      carry_cnt  = 0;
      hdr_done   = 1'b0;
    end else begin
      carry_bits = acc_byte[6:0];
      carry_cnt  = acc_cnt;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MaxReports) $display("%0t ns: ERROR %s", $time, msg);
  endtask

  // Mostly no gap or a short one; now and then a long one.
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic in_item_t make_item(input mode_e m, input logic [15:0] v,
                                         input logic [31:0] sum);
    in_item_t it;
    it.mode     = m;
    it.value    = v;
    it.checksum = sum;
    return it;
  endfunction

  function automatic stim_row_t row(input mode_e m, input logic [15:0] v,
                                    input logic [31:0] sum, input logic [2:0] n,
                                    input logic [0:5][7:0] bytes);
    stim_row_t r;
    r.item    = make_item(m, v, sum);
    r.n_typed = n;
    r.typed   = bytes;
    return r;
  endfunction

  // Present one transaction, hold it until accepted, then queue its bytes.
  // Typed-in bytes replace the packer's answer; the packer still advances.
  task automatic send_symbol(input in_item_t it, input logic [2:0] n_typed = '0,
                             input logic [0:5][7:0] typed = '0);
    int gap;
    int unsigned n;
    out_item_t res;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall !== 1'b0);
    encode_item(it);
    if (n_typed != 0) begin
      coded_bytes.delete();
      for (int i = 0; i < int'(n_typed); i++) add_coded(typed[i]);
    end
    n = coded_bytes.size();
    if (n == 0) silent_items++;
    for (int i = 0; i < int'(n); i++) begin
      res.out_byte      = coded_bytes[i];
      res.last_of_item  = (i == int'(n) - 1);
      res.end_of_stream = (i == int'(n) - 1) && (it.mode == MODE_FINISH);
      expected_bytes = {expected_bytes, res};
    end
    mode_count[it.mode]++;
    if (it.mode == MODE_FINISH) streams_done++;
  endtask

  // Length mix: short codes, the full range, and the top end near 258.
  function automatic logic [15:0] pick_length();
    case ($urandom_range(0, 2))
      0:       return 16'($urandom_range(3, 10));
      1:       return 16'($urandom_range(3, 258));
      default: return 16'($urandom_range(250, 258));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  stim_row_t directed_rows [NumDirected];

  initial begin : stimulus
    int unsigned n_sym;
    int unsigned pick;
    logic [31:0] dist_val;

    directed_rows = '{
      // Finish straight out of reset: block header, end-of-block, checksum.
      row(MODE_FINISH,   16'h0000, 32'hFFFF_FFFF, 3'd6,
          {8'h03, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF}),
      // First literal opens a stream: zlib header then header + code 0x30.
      row(MODE_LITERAL,  16'h0000, 32'h0, 3'd3,
          {8'h78, 8'h5E, 8'h63, 8'h00, 8'h00, 8'h00}),
      row(MODE_LITERAL,  16'd143,   32'h0, 3'd0, '0),
      row(MODE_LITERAL,  16'd144,   32'h0, 3'd0, '0),
      row(MODE_LITERAL,  16'd255,   32'h0, 3'd0, '0),
      row(MODE_LITERAL,  16'hFFFF,  32'h0, 3'd0, '0),   // clamps to 255
      row(MODE_LENGTH,   16'd0,     32'h0, 3'd0, '0),   // clamps to 3
      row(MODE_LENGTH,   16'd3,     32'h0, 3'd0, '0),
      row(MODE_LENGTH,   16'd10,    32'h0, 3'd0, '0),   // last length without extra
      row(MODE_LENGTH,   16'd11,    32'h0, 3'd0, '0),   // first with extra bits
      row(MODE_LENGTH,   16'd257,   32'h0, 3'd0, '0),
      row(MODE_LENGTH,   16'd258,   32'h0, 3'd0, '0),
      row(MODE_LENGTH,   16'hFFFF,  32'h0, 3'd0, '0),   // clamps to 258
      row(MODE_DISTANCE, 16'd0,     32'h0, 3'd0, '0),   // clamps to 1
      row(MODE_DISTANCE, 16'd1,     32'h0, 3'd0, '0),
      row(MODE_DISTANCE, 16'd4,     32'h0, 3'd0, '0),
      row(MODE_DISTANCE, 16'd5,     32'h0, 3'd0, '0),
      row(MODE_DISTANCE, 16'd32768, 32'h0, 3'd0, '0),
      row(MODE_DISTANCE, 16'hFFFF,  32'h0, 3'd0, '0),   // clamps to 32768
      row(MODE_FINISH,   16'hFFFF,  32'h0000_0000, 3'd0, '0),
      // Finish with no symbol since the last one: no zlib header bytes.
      row(MODE_FINISH,   16'h0000, 32'h1234_5678, 3'd6,
          {8'h03, 8'h00, 8'h12, 8'h34, 8'h56, 8'h78}),
      row(MODE_DISTANCE, 16'd200,   32'h0, 3'd0, '0),   // stream opened by a distance
      row(MODE_FINISH,   16'h0000, 32'hA5A5_5A5A, 3'd0, '0)
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      send_symbol(directed_rows[r].item, directed_rows[r].n_typed, directed_rows[r].typed);
    end

    // Random streams: mostly well-formed symbol runs closed by a finish,
    // with some raw noise (any mode, any value) mixed in.
    while (random_items < RandomItems) begin
      n_sym = $urandom_range(1, 24);
      for (int k = 0; k < int'(n_sym); k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          send_symbol(make_item(MODE_LITERAL, 16'($urandom_range(0, 255)), $urandom));
          random_items++;
        end else if (pick < 90) begin
          dist_val = 1 + ($urandom & ((32'd1 << $urandom_range(0, 15)) - 1));
          send_symbol(make_item(MODE_LENGTH, pick_length(), $urandom));
          send_symbol(make_item(MODE_DISTANCE, dist_val[15:0], $urandom));
          random_items += 2;
        end else begin
          send_symbol(make_item(mode_e'($urandom_range(0, 3)),
                                16'($urandom_range(0, 16'hFFFF)), $urandom));
          random_items++;
        end
      end
      send_symbol(make_item(MODE_FINISH, 16'($urandom_range(0, 16'hFFFF)), $urandom));
      random_items++;
    end
    in_valid <= 1'b0;

    // Drain: wait for every owed byte, then give stray bytes time to show.
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Covered %0d transactions (%0d directed) in %0d streams; %0d bytes checked.",
             NumDirected + random_items, NumDirected, streams_done, bytes_checked);
    $display("Mix: %0d literal, %0d length, %0d distance, %0d finish; %0d made no byte.",
             mode_count[MODE_LITERAL], mode_count[MODE_LENGTH],
             mode_count[MODE_DISTANCE], mode_count[MODE_FINISH], silent_items);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Output stall: runs of open cycles broken by random stall stretches.
  // --------------------------------------------------------------------------
  initial begin : byte_sink
    int gap;
    wait (rst_n);
    forever begin
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Byte checker: compare each accepted byte with the oldest owed one.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      bytes_checked++;
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("byte %02h with nothing owed", out_item.out_byte));
      end else begin
        want = expected_bytes.pop_front();
        if (out_item.out_byte !== want.out_byte)
          report_mismatch($sformatf("out_byte %02h, want %02h",
                                    out_item.out_byte, want.out_byte));
        if (out_item.last_of_item !== want.last_of_item)
          report_mismatch($sformatf("last_of_item %b, want %b on byte %02h",
                                    out_item.last_of_item, want.last_of_item,
                                    want.out_byte));
        if (out_item.end_of_stream !== want.end_of_stream)
          report_mismatch($sformatf("end_of_stream %b, want %b on byte %02h",
                                    out_item.end_of_stream, want.end_of_stream,
                                    want.out_byte));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run if neither side moves a transaction for too long.
  // --------------------------------------------------------------------------
  int unsigned idle_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WatchdogLimit) begin
        $display("Watchdog: no transaction for %0d cycles, %0d bytes still owed",
                 WatchdogLimit, expected_bytes.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
